[hdl/indexed_statistics_counter_table_defines.svh]
// assertion macros for the indexed statistics counter table
`ifndef INDEXED_STATISTICS_COUNTER_TABLE_DEFINES_SVH
`define INDEXED_STATISTICS_COUNTER_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ISCT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("isct assertion failed");
// expression must never be true outside reset
`define ISCT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("isct forbidden condition seen");
`else
`define ISCT_ASSERT(lbl, prop)
`define ISCT_NEVER(lbl, expr)
`endif

`endif

[hdl/isct_pkg.sv]
// types and constants for the indexed statistics counter table
package isct_pkg;

	localparam int IDX_W   = 5;
	localparam int VAL_W   = 64;
	localparam int MASK_W  = 32;
	localparam int CFG_W   = 2;
	localparam int HALF_W  = 32;

	// configuration register indexes
	localparam logic [CFG_W-1:0] CFG_MINMAX_MASK = 2'd0;
	localparam logic [CFG_W-1:0] CFG_SQUARE_MASK = 2'd1;

	// operations
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	// one table entry, count in the lowest bits
	typedef struct packed {
		logic [VAL_W-1:0] largest;
		logic [VAL_W-1:0] smallest;
		logic [VAL_W-1:0] square_sum;
		logic [VAL_W-1:0] sum;
		logic [VAL_W-1:0] count;
	} entry_t;

	localparam logic [VAL_W-1:0] MIN_RESET = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] MAX_RESET = {1'b1, {(VAL_W-1){1'b0}}};

	localparam entry_t ENTRY_RESET = '{
		largest:    MAX_RESET,
		smallest:   MIN_RESET,
		square_sum: '0,
		sum:        '0,
		count:      '0
	};

endpackage

[hdl/indexed_statistics_counter_table.sv]
// indexed statistics counter table: per-entry count, sum, sum of squares, min and max
// One item is in flight at a time: in the accept cycle the entry is read from the
// synchronous entry memory and the two 32x32 partial products of the square are
// formed; in the update stage the entry is updated, written back and loaded into
// the output register. s_tready stays low while the update stage holds an item, so
// no new item is taken until the last one has left it; a full output register that
// is not taken holds the item in the update stage. An index at or above NUM_ENTRIES
// leaves the table alone and returns a beat with the error flag set and all data
// zero. After reset every entry reads as cleared (zero counts and sums, min at the
// largest signed value, max at the most negative) through per-entry valid flops, so
// there is no clearing pass. The user must write configuration masks only while the
// block is idle; the block itself does not enforce this.
`include "indexed_statistics_counter_table_defines.svh"

module indexed_statistics_counter_table #(
	parameter int NUM_ENTRIES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input item stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [71:0]                   s_tdata,   // entry_index[4:0], amount[68:5], zero pad
	input  logic                          s_tuser,   // opcode
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [319:0]                  m_tdata,   // event_count, running_sum,
	                                                 // running_square_sum, smallest_seen,
	                                                 // largest_seen (64 bits each)
	output logic                          m_tuser,   // index_error
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [isct_pkg::CFG_W-1:0]    cfg_index,
	input  logic [isct_pkg::MASK_W-1:0]   cfg_data
);

	localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	// unpacked input fields
	logic [isct_pkg::IDX_W-1:0]  in_index;
	logic [isct_pkg::VAL_W-1:0]  in_amount;
	logic                        in_accept;
	logic                        in_range;
	logic [AW-1:0]               in_addr;

	assign in_index  = s_tdata[isct_pkg::IDX_W-1:0];
	assign in_amount = s_tdata[isct_pkg::IDX_W +: isct_pkg::VAL_W];
	assign in_accept = s_tvalid && s_tready;
	assign in_range  = (int'(in_index) < NUM_ENTRIES);
	assign in_addr   = in_index[AW-1:0];

	// configuration registers, always ready
	logic [isct_pkg::MASK_W-1:0] minmax_mask_q;
	logic [isct_pkg::MASK_W-1:0] square_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minmax_mask_q <= '0;
			square_mask_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				isct_pkg::CFG_MINMAX_MASK: minmax_mask_q <= cfg_data;
				isct_pkg::CFG_SQUARE_MASK: square_mask_q <= cfg_data;
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// entry memory and its per-entry valid flops
	isct_pkg::entry_t           mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0]     valid_q;

	// update stage registers
	logic                        v_s1;
	logic                        op_s1;
	logic                        err_s1;
	logic [isct_pkg::IDX_W-1:0]  idx_s1;
	logic [isct_pkg::VAL_W-1:0]  amt_s1;
	logic                        vld_s1;
	isct_pkg::entry_t            rd_s1;
	logic [isct_pkg::VAL_W-1:0]  sq_lo_s1;  // low half squared
	logic [isct_pkg::HALF_W-1:0] sq_x_s1;   // low half times high half, low 32 bits

	// output register
	logic                        m_valid_q;
	logic                        m_err_q;
	isct_pkg::entry_t            m_data_q;

	logic done_s1;
	assign done_s1  = v_s1 && (!m_valid_q || m_tready);
	// one item in flight: no new beat until the update stage has drained
	assign s_tready = !v_s1;

	// partial products of the square from the incoming amount
	logic [isct_pkg::HALF_W-1:0] amt_lo;
	logic [isct_pkg::HALF_W-1:0] amt_hi;
	logic [2*isct_pkg::HALF_W-1:0] prod_cross;
	assign amt_lo     = in_amount[isct_pkg::HALF_W-1:0];
	assign amt_hi     = in_amount[isct_pkg::VAL_W-1:isct_pkg::HALF_W];
	assign prod_cross = amt_lo * amt_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (done_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// stage payload and synchronous memory read
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= s_tuser;
			err_s1   <= !in_range;
			idx_s1   <= in_index;
			amt_s1   <= in_amount;
			sq_lo_s1 <= amt_lo * amt_lo;
			sq_x_s1  <= prod_cross[isct_pkg::HALF_W-1:0];
			if (in_range) begin
				rd_s1  <= mem[in_addr];
				vld_s1 <= valid_q[in_addr];
			end
		end
	end

	// read-modify of the entry
	isct_pkg::entry_t old_entry;
	isct_pkg::entry_t new_entry;
	logic             mm_en;
	logic             sq_en;
	logic [isct_pkg::VAL_W-1:0] square;

	assign old_entry = vld_s1 ? rd_s1 : isct_pkg::ENTRY_RESET;
	assign mm_en     = minmax_mask_q[idx_s1];
	assign sq_en     = mm_en && square_mask_q[idx_s1];
	// a*a mod 2^64 = lo*lo + (lo*hi << 33)
	assign square    = sq_lo_s1 + {sq_x_s1[isct_pkg::HALF_W-2:0], {(isct_pkg::HALF_W+1){1'b0}}};

	always_comb begin
		new_entry = old_entry;
		if (op_s1 == isct_pkg::OP_ADD) begin
			new_entry.count = old_entry.count + 64'd1;
			if (mm_en) begin
				new_entry.sum = old_entry.sum + amt_s1;
				if (sq_en) begin
					new_entry.square_sum = old_entry.square_sum + square;
				end
				if ($signed(amt_s1) < $signed(old_entry.smallest)) begin
					new_entry.smallest = amt_s1;
				end
				if ($signed(old_entry.largest) < $signed(amt_s1)) begin
					new_entry.largest = amt_s1;
				end
			end
		end else if (mm_en) begin
			new_entry.sum = old_entry.sum - amt_s1;
		end
	end

	// write back
	logic wr_en;
	assign wr_en = done_s1 && !err_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s1[AW-1:0]] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[idx_s1[AW-1:0]] <= 1'b1;
		end
	end

	// output register, loaded as the update stage completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			m_err_q  <= err_s1;
			m_data_q <= err_s1 ? '0 : new_entry;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_err_q;
	assign m_tdata  = m_data_q;

	// checks
	`ISCT_NEVER(a_no_accept_busy, v_s1 && in_accept)
	`ISCT_ASSERT(a_no_write_on_err, wr_en |-> !err_s1 && v_s1)
	`ISCT_ASSERT(a_result_from_stage, $rose(m_valid_q) |-> $past(v_s1))
	`ISCT_ASSERT(a_min_le_max,
		(done_s1 && !err_s1 && mm_en && op_s1 == isct_pkg::OP_ADD) |=>
		($signed(m_data_q.smallest) <= $signed(m_data_q.largest)))

endmodule
